// ===== rtl/core/rgbhsl_pkg.sv =====
package rgbhsl_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [8:0]  hue_deg;
        logic [12:0] sat_frac;
        logic [8:0]  light_twice;
    } hsl_t;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    localparam int unsigned HUE_Q_BITS     = 6;   // 60*|diff|/chroma never exceeds 60
    localparam int unsigned HUE_NUM_BITS   = 14;  // 60*255 fits in 14 bits
    localparam logic [8:0]  HUE_GREEN_BASE = 9'd120;
    localparam logic [8:0]  HUE_BLUE_BASE  = 9'd240;
    localparam logic [8:0]  HUE_WRAP       = 9'd360;
    localparam logic [12:0] SAT_FIELD_MAX  = 13'd8191;

endpackage

// ===== rtl/core/rgb_to_hsl_pixel.sv =====
// A pixel word passes the front-end register, the divide stage registers and the output
// register. Throughput: one word per cycle, limited by nothing but stall.
// One restoring divide step per pipeline stage; hue quotient is done in the first six.
// Stall back-pressure collapses bubbles; stages only hold when the stage ahead is full.
// Reset clears all valid bits; the datapath registers are not reset.
module rgb_to_hsl_pixel #(
    parameter int unsigned SAT_FRAC_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_stall,
    input  rgbhsl_pkg::pixel_t  pix,
    output logic                hsl_valid,
    input  logic                hsl_stall,
    output rgbhsl_pkg::hsl_t    hsl
);

    localparam int unsigned QW = SAT_FRAC_BITS + 1;      // sat quotient bits = divide stages
    localparam int unsigned CW = (QW > 13) ? QW : 13;
    localparam int unsigned HQ = rgbhsl_pkg::HUE_Q_BITS;
    localparam int unsigned HW = rgbhsl_pkg::HUE_NUM_BITS;

    // stage registers, index 0 is the front-end stage, index j+1 follows divide step j
    logic [QW:0]           v_reg;
    logic [7:0]            c_reg     [0:QW];
    logic [7:0]            den_reg   [0:QW];
    logic [7:0]            srem_reg  [0:QW];
    logic [QW-1:0]         squo_reg  [0:QW];
    logic [HW-1:0]         hrem_reg  [0:QW];
    logic [HQ-1:0]         hquo_reg  [0:QW];
    rgbhsl_pkg::sector_t   sec_reg   [0:QW];
    logic                  neg_reg   [0:QW];
    logic [8:0]            sum_reg   [0:QW];

    logic [7:0]            srem_next [1:QW];
    logic [QW-1:0]         squo_next [1:QW];
    logic [HW-1:0]         hrem_next [1:QW];
    logic [HQ-1:0]         hquo_next [1:QW];

    logic                  hsl_valid_reg;
    rgbhsl_pkg::hsl_t      hsl_reg;
    rgbhsl_pkg::hsl_t      hsl_next;

    logic [QW+1:0]         rdy;

    // front end
    logic [7:0]            mx, mn, da, db, mag;
    logic [8:0]            sum0;
    logic [7:0]            den0;
    rgbhsl_pkg::sector_t   sec0;
    logic                  neg0;
    logic [HW-1:0]         num0;

    always_comb
    begin
        if (pix.red >= pix.green && pix.red >= pix.blue)
        begin
            sec0 = rgbhsl_pkg::SEC_RED;
            mx   = pix.red;
            da   = pix.green;
            db   = pix.blue;
        end
        else if (pix.green >= pix.blue)
        begin
            sec0 = rgbhsl_pkg::SEC_GREEN;
            mx   = pix.green;
            da   = pix.blue;
            db   = pix.red;
        end
        else
        begin
            sec0 = rgbhsl_pkg::SEC_BLUE;
            mx   = pix.blue;
            da   = pix.red;
            db   = pix.green;
        end
        mn = pix.red;
        if (pix.green < mn)
            mn = pix.green;
        if (pix.blue < mn)
            mn = pix.blue;
        sum0 = {1'b0, mx} + {1'b0, mn};
        den0 = (sum0 >= 9'd255) ? 8'(9'd510 - sum0) : sum0[7:0];
        neg0 = db > da;
        mag  = neg0 ? (db - da) : (da - db);
        num0 = (HW'(mag) << 6) - (HW'(mag) << 2);
    end

    // ready chain, back to front
    always_comb
    begin
        rdy[QW+1] = !hsl_valid_reg || !hsl_stall;
        for (int k = QW; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign pix_stall = !rdy[0];

    // divide steps: one saturation bit per stage, one hue bit in the first HQ stages
    always_comb
    begin
        logic [8:0]    r2;
        logic          sge;
        logic [HW-1:0] dsh;
        logic          hge;
        for (int j = 0; j < QW; j++)
        begin
            // first step yields the integer bit, no shift
            if (j == 0)
                r2 = {1'b0, srem_reg[j]};
            else
                r2 = {srem_reg[j], 1'b0};
            sge = r2 >= {1'b0, den_reg[j]};
            srem_next[j+1] = sge ? 8'(r2 - {1'b0, den_reg[j]}) : r2[7:0];
            squo_next[j+1] = {squo_reg[j][QW-2:0], sge};
            if (j < HQ)
            begin
                dsh = HW'(c_reg[j]) << (HQ - 1 - j);
                hge = hrem_reg[j] >= dsh;
                hrem_next[j+1] = hge ? (hrem_reg[j] - dsh) : hrem_reg[j];
                hquo_next[j+1] = {hquo_reg[j][HQ-2:0], hge};
            end
            else
            begin
                hrem_next[j+1] = hrem_reg[j];
                hquo_next[j+1] = hquo_reg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            hsl_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= pix_valid;
            for (int k = 1; k <= QW; k++)
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
            if (rdy[QW+1])
                hsl_valid_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && pix_valid)
        begin
            c_reg[0]    <= mx - mn;
            den_reg[0]  <= den0;
            srem_reg[0] <= mx - mn;
            squo_reg[0] <= '0;
            hrem_reg[0] <= num0;
            hquo_reg[0] <= '0;
            sec_reg[0]  <= sec0;
            neg_reg[0]  <= neg0;
            sum_reg[0]  <= sum0;
        end
        for (int k = 1; k <= QW; k++)
        begin
            if (rdy[k] && v_reg[k-1])
            begin
                c_reg[k]    <= c_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                srem_reg[k] <= srem_next[k];
                squo_reg[k] <= squo_next[k];
                hrem_reg[k] <= hrem_next[k];
                hquo_reg[k] <= hquo_next[k];
                sec_reg[k]  <= sec_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                sum_reg[k]  <= sum_reg[k-1];
            end
        end
        if (rdy[QW+1] && v_reg[QW])
            hsl_reg <= hsl_next;
    end

    // final compose: hue from sector, sign and quotient; saturation clamp; zero chroma forces hue and saturation to 0
    always_comb
    begin
        logic [8:0]    q9;
        logic [8:0]    base;
        logic          remnz;
        logic [CW-1:0] sq;
        q9    = 9'(hquo_reg[QW]);
        remnz = hrem_reg[QW] != '0;
        sq    = CW'(squo_reg[QW]);
        base  = rgbhsl_pkg::HUE_BLUE_BASE;
        hsl_next.light_twice = sum_reg[QW];
        case (sec_reg[QW])
            rgbhsl_pkg::SEC_RED:
            begin
                if (!neg_reg[QW])
                    hsl_next.hue_deg = q9;
                else if (q9 == 9'd0)
                    hsl_next.hue_deg = 9'd0;
                else
                    hsl_next.hue_deg = rgbhsl_pkg::HUE_WRAP - q9;
            end
            default:
            begin
                if (sec_reg[QW] == rgbhsl_pkg::SEC_GREEN)
                    base = rgbhsl_pkg::HUE_GREEN_BASE;
                // negative offset floors, so a nonzero remainder takes one more off
                if (neg_reg[QW])
                    hsl_next.hue_deg = base - q9 - 9'(remnz);
                else
                    hsl_next.hue_deg = base + q9;
            end
        endcase
        if (sq > CW'(rgbhsl_pkg::SAT_FIELD_MAX))
            hsl_next.sat_frac = rgbhsl_pkg::SAT_FIELD_MAX;
        else
            hsl_next.sat_frac = sq[12:0];
        if (c_reg[QW] == 8'd0)
        begin
            hsl_next.hue_deg  = 9'd0;
            hsl_next.sat_frac = 13'd0;
        end
    end

    assign hsl_valid = hsl_valid_reg;
    assign hsl       = hsl_reg;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid_reg |-> hsl_reg.hue_deg <= 9'd359)
        else $error("hue out of range");

    a_hue_implies_sat: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid_reg && hsl_reg.hue_deg != 9'd0 |-> hsl_reg.sat_frac != 13'd0)
        else $error("chromatic word with zero saturation");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid_reg |-> CW'(hsl_reg.sat_frac) <= (CW'(1) << SAT_FRAC_BITS))
        else $error("saturation above one");

    a_stall_front: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (&v_reg) && hsl_valid_reg)
        else $error("input stalled with a bubble in the pipe");

endmodule

// ===== bench/testbench.sv =====
module testbench;

    localparam int unsigned SAT_BITS = 12;
    localparam int unsigned LATENCY  = SAT_BITS + 2;
    localparam int unsigned N_RANDOM = 1350;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    class hsl_scoreboard;
        rgbhsl_pkg::hsl_t hsl_due[$];
        int               errors = 0;

        function rgbhsl_pkg::hsl_t to_hsl(rgbhsl_pkg::pixel_t p);
            int                  r, g, b, mx, mn, sum, chroma, denom, hue;
            longint              sat;
            rgbhsl_pkg::sector_t sec;
            rgbhsl_pkg::hsl_t    res;
            r = p.red;
            g = p.green;
            b = p.blue;
            mx = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            mn = r;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            sum = mx + mn;
            chroma = mx - mn;
            // ties go to red, then green
            if (mx == r)
                sec = rgbhsl_pkg::SEC_RED;
            else if (mx == g)
                sec = rgbhsl_pkg::SEC_GREEN;
            else
                sec = rgbhsl_pkg::SEC_BLUE;
            if (chroma == 0)
            begin
                hue = 0;
                sat = 0;
            end
            else
            begin
                denom = 255 - ((sum >= 255) ? sum - 255 : 255 - sum);
                if (denom < 1) denom = 1;
                sat = (longint'(chroma) << SAT_BITS) / denom;
                if (sat > 8191) sat = 8191;
                // int division truncates toward zero
                case (sec)
                    rgbhsl_pkg::SEC_RED:
                    begin
                        hue = (60 * (g - b)) / chroma;
                        if (hue < 0) hue += 360;
                    end
                    rgbhsl_pkg::SEC_GREEN: hue = (120 * chroma + 60 * (b - r)) / chroma;
                    default:               hue = (240 * chroma + 60 * (r - g)) / chroma;
                endcase
                if (hue < 0) hue = 0;
                if (hue > 359) hue = 359;
            end
            res.hue_deg     = hue[8:0];
            res.sat_frac    = sat[12:0];
            res.light_twice = sum[8:0];
            return res;
        endfunction

        function void note_pixel(rgbhsl_pkg::pixel_t p);
            hsl_due.push_back(to_hsl(p));
        endfunction

        function void check_hsl(rgbhsl_pkg::hsl_t got);
            rgbhsl_pkg::hsl_t want;
            if (hsl_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word hue=%0d sat=%0d light=%0d", $time,
                         got.hue_deg, got.sat_frac, got.light_twice);
                return;
            end
            want = hsl_due.pop_front();
            if (got.hue_deg !== want.hue_deg)
            begin
                errors++;
                $display("%0t: hue_deg expected %0d got %0d", $time,
                         want.hue_deg, got.hue_deg);
            end
            if (got.sat_frac !== want.sat_frac)
            begin
                errors++;
                $display("%0t: sat_frac expected %0d got %0d", $time,
                         want.sat_frac, got.sat_frac);
            end
            if (got.light_twice !== want.light_twice)
            begin
                errors++;
                $display("%0t: light_twice expected %0d got %0d", $time,
                         want.light_twice, got.light_twice);
            end
        endfunction

        function int pending();
            return hsl_due.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               pix_valid;
    logic               pix_stall;
    rgbhsl_pkg::pixel_t pix;
    logic               hsl_valid;
    logic               hsl_stall = 1'b0;
    rgbhsl_pkg::hsl_t   hsl;

    hsl_scoreboard sb = new;

    stall_mode_t stall_mode  = STALL_NONE;
    int          stall_left  = 0;
    int          stall_phase = 0;

    rgb_to_hsl_pixel #(
        .SAT_FRAC_BITS(SAT_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix      (pix),
        .hsl_valid(hsl_valid),
        .hsl_stall(hsl_stall),
        .hsl      (hsl)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #1000000;
        $display("rgb_to_hsl_pixel: mismatch");
        $finish;
    end

    // receiver back-pressure, in a randomly chosen mode that is redrawn when its countdown runs out
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        stall_phase <= (stall_phase + 1) % 5;
        case (stall_mode)
            STALL_NONE:     hsl_stall <= 1'b0;
            STALL_LIGHT:    hsl_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY:    hsl_stall <= ($urandom_range(0, 9) < 8);
            default:        hsl_stall <= (stall_phase < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && hsl_valid && !hsl_stall)
            sb.check_hsl(hsl);
    end

    function automatic int clamp8(int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic rgbhsl_pkg::pixel_t arrange(int a, int b, int c, int perm);
        rgbhsl_pkg::pixel_t p;
        case (perm)
            0: p = '{red: a[7:0], green: b[7:0], blue: c[7:0]};
            1: p = '{red: a[7:0], green: c[7:0], blue: b[7:0]};
            2: p = '{red: b[7:0], green: a[7:0], blue: c[7:0]};
            3: p = '{red: b[7:0], green: c[7:0], blue: a[7:0]};
            4: p = '{red: c[7:0], green: a[7:0], blue: b[7:0]};
            default: p = '{red: c[7:0], green: b[7:0], blue: a[7:0]};
        endcase
        return p;
    endfunction

    function automatic rgbhsl_pkg::pixel_t random_pixel();
        int kind, base, hi, lo, mid;
        kind = $urandom_range(0, 9);
        if (kind <= 4)
            return rgbhsl_pkg::pixel_t'(24'($urandom_range(0, 24'hffffff)));
        case (kind)
            5:
            begin
                // near gray: chroma of at most 6 counts
                base = $urandom_range(0, 255);
                return arrange(clamp8(base + $urandom_range(0, 6) - 3),
                               clamp8(base + $urandom_range(0, 6) - 3),
                               clamp8(base + $urandom_range(0, 6) - 3), 0);
            end
            6:
            begin
                // two components share the maximum
                hi = $urandom_range(1, 255);
                lo = $urandom_range(0, hi);
                return arrange(hi, hi, lo, $urandom_range(0, 5));
            end
            7:
            begin
                // max + min around 255, where the saturation divisor peaks
                hi = $urandom_range(128, 255);
                lo = 255 - hi + $urandom_range(0, 4) - 2;
                if (lo < 0) lo = 0;
                if (lo > hi) lo = hi;
                mid = $urandom_range(lo, hi);
                return arrange(hi, mid, lo, $urandom_range(0, 5));
            end
            8:
            begin
                hi = $urandom_range(0, 1) ? 255 : 0;
                lo = $urandom_range(0, 1) ? 255 : 0;
                return arrange(hi, lo, $urandom_range(0, 255), $urandom_range(0, 5));
            end
            default:
            begin
                base = $urandom_range(0, 255);
                return arrange(base, base, base, 0);
            end
        endcase
    endfunction

    task automatic send_word(rgbhsl_pkg::pixel_t p);
        @(negedge clk);
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (pix_stall);
        sb.note_pixel(p);
    endtask

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            pix_valid <= 1'b0;
            pix       <= rgbhsl_pkg::pixel_t'(24'($urandom_range(0, 24'hffffff)));
        end
    endtask

    initial
    begin
        rgbhsl_pkg::pixel_t directed[$];
        int                 sent;
        int                 burst;
        directed = '{
            '{8'd0,   8'd0,   8'd0},     // black
            '{8'd255, 8'd255, 8'd255},   // white
            '{8'd128, 8'd128, 8'd128},   // mid gray
            '{8'd255, 8'd0,   8'd0},
            '{8'd0,   8'd255, 8'd0},
            '{8'd0,   8'd0,   8'd255},
            '{8'd255, 8'd255, 8'd0},     // red/green tie
            '{8'd0,   8'd255, 8'd255},   // green/blue tie
            '{8'd255, 8'd0,   8'd255},   // red/blue tie, wraps to 300
            '{8'd255, 8'd0,   8'd128},   // negative red hue
            '{8'd255, 8'd0,   8'd1},     // small negative truncates to 0
            '{8'd255, 8'd0,   8'd5},     // wraps to 359
            '{8'd254, 8'd0,   8'd255},
            '{8'd1,   8'd0,   8'd0},     // tiny divisor, dark
            '{8'd255, 8'd254, 8'd254},   // tiny divisor, bright
            '{8'd128, 8'd127, 8'd127},   // sum exactly 255
            '{8'd127, 8'd128, 8'd128},
            '{8'd200, 8'd100, 8'd50},
            '{8'd50,  8'd200, 8'd100},
            '{8'd100, 8'd50,  8'd200},
            '{8'd0,   8'd1,   8'd255},
            '{8'd170, 8'd85,  8'd255}
        };

        rst_n     = 1'b0;
        pix_valid = 1'b0;
        pix       = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_word(directed[i]);

        sent = 0;
        while (sent < N_RANDOM)
        begin
            burst = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < N_RANDOM; k++)
            begin
                send_word(random_pixel());
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 8));
        end
        idle_cycles(1);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3 * LATENCY) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("rgb_to_hsl_pixel: match");
        else
            $display("rgb_to_hsl_pixel: mismatch");
        $finish;
    end

endmodule
